FILE: sv/wlt_pkg.sv
package wlt_pkg;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned TimeW  = 64;
  localparam int unsigned StW    = 2;
  localparam int unsigned CntW   = 6;
  localparam int unsigned CmdW   = 4;
  localparam int unsigned StsW   = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW   = 32;

  localparam logic [CmdW-1:0] CmdAdd      = 4'd0;
  localparam logic [CmdW-1:0] CmdRemove   = 4'd1;
  localparam logic [CmdW-1:0] CmdSetState = 4'd2;
  localparam logic [CmdW-1:0] CmdBeat     = 4'd3;
  localparam logic [CmdW-1:0] CmdLookup   = 4'd4;
  localparam logic [CmdW-1:0] CmdCount    = 4'd5;
  localparam logic [CmdW-1:0] CmdCountSt  = 4'd6;
  localparam logic [CmdW-1:0] CmdSnapshot = 4'd7;
  localparam logic [CmdW-1:0] CmdTimeout  = 4'd8;

  localparam logic [StsW-1:0] StsOk       = 2'd0;
  localparam logic [StsW-1:0] StsNotFound = 2'd1;
  localparam logic [StsW-1:0] StsFull     = 2'd2;
  localparam logic [StsW-1:0] StsEmptyKey = 2'd3;

  localparam logic [StW-1:0] StAvailable = 2'd0;
  localparam logic [StW-1:0] StSuspect   = 2'd2;

  localparam logic [CfgIdxW-1:0] RegTimeout = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLimit   = 2'd1;

  localparam logic [CntW-1:0] MaxReport = 6'd32;
  localparam logic [31:0]     TimeoutRst = 32'd3000;

  typedef struct packed {
    logic [KeyW-1:0]  kh;
    logic [KeyW-1:0]  kl;
    logic [StW-1:0]   st;
    logic [TimeW-1:0] hb;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_FIN   = 5'b00100,
    S_REMRD = 5'b01000,
    S_REMWR = 5'b10000
  } state_e;

endpackage

FILE: sv/wlt_mem.sv
module wlt_mem
  import wlt_pkg::*;
#(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output entry_t           rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  entry_t           wr_data_i
);

  entry_t mem_q [Depth];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: sv/worker_liveness_table_core.sv
// Channel  Handshake                 Payload
// in       in_valid_i / in_ready_o   command, key_high, key_low, state_value, time_ms
// out      out_valid_o / out_ready_i status, last, entry key/state/heartbeat, tally
// cfg      cfg_we_i (no wait)        cfg_index_i, cfg_data_i
//
// One request at a time. A scanning request reads up to occupancy table entries,
// one per cycle unless held, from the single entry memory; a key match ends the
// scan early, as does the report limit for a snapshot. Remove then reads the last
// entry and moves it into the freed slot. Count and an empty-key add skip the scan.
// Reset empties the table and loads the register defaults; no clearing pass.
// The scan holds whenever a result is due and the output register is full.
module worker_liveness_table_core
  import wlt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CmdW-1:0]    command_i,
  input  logic [KeyW-1:0]    key_high_i,
  input  logic [KeyW-1:0]    key_low_i,
  input  logic [StW-1:0]     state_value_i,
  input  logic [TimeW-1:0]   time_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StsW-1:0]    status_o,
  output logic               last_o,
  output logic [KeyW-1:0]    entry_key_high_o,
  output logic [KeyW-1:0]    entry_key_low_o,
  output logic [StW-1:0]     entry_state_o,
  output logic [TimeW-1:0]   entry_heartbeat_o,
  output logic [CntW-1:0]    tally_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CntW-1:0] DepthC = CntW'(TABLE_DEPTH);

  state_e state_q, state_d;
  logic [31:0]       timeout_q;
  logic [CntW-1:0]   limit_q;
  logic [CntW-1:0]   occ_q, occ_d;
  logic [CmdW-1:0]   cmd_q;
  logic [KeyW-1:0]   kh_q, kl_q;
  logic [StW-1:0]    sv_q;
  logic [TimeW-1:0]  tm_q;
  logic              ekey_q;
  logic [CntW-1:0]   lim_q;
  logic [CntW-1:0]   idx_q, idx_d, chk_q, chk_d;
  logic              v1_q, v1_d;
  logic [CntW-1:0]   cnt_q, cnt_d, k_q, k_d;
  logic              found_q, found_d;
  logic [CntW-1:0]   slot_q, slot_d;
  entry_t            hit_q, hit_d;

  logic              rd_en, wr_en;
  logic [AddrW-1:0]  rd_addr, wr_addr;
  entry_t            rd_data, wr_data;

  logic              ovalid_q;
  logic [StsW-1:0]   osts_q;
  logic              olast_q;
  entry_t            oent_q;
  logic [CntW-1:0]   otally_q;
  logic              emit;
  logic [StsW-1:0]   e_sts;
  logic              e_last;
  entry_t            e_ent;
  logic [CntW-1:0]   e_tally;

  logic ofree, accept, find_cmd, key_eq, elig, need_emit, stall, issue;

  wlt_mem #(.Depth(TABLE_DEPTH), .AddrW(AddrW)) u_mem (
    .clk_i,
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign ofree  = !ovalid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept = in_valid_i && in_ready_o;
  assign find_cmd = (cmd_q == CmdAdd) || (cmd_q == CmdRemove) || (cmd_q == CmdSetState) ||
                    (cmd_q == CmdBeat) || (cmd_q == CmdLookup);
  assign key_eq = v1_q && (rd_data.kh == kh_q) && (rd_data.kl == kl_q);
  assign elig   = v1_q && (rd_data.st < StSuspect) && (rd_data.hb != '0) &&
                  (tm_q >= rd_data.hb) && ((tm_q - rd_data.hb) > {32'd0, timeout_q});

  always_comb begin
    state_d = state_q;
    occ_d   = occ_q;
    idx_d   = idx_q;
    chk_d   = chk_q;
    v1_d    = v1_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    found_d = found_q;
    slot_d  = slot_q;
    hit_d   = hit_q;
    rd_en   = 1'b0;
    rd_addr = idx_q[AddrW-1:0];
    wr_en   = 1'b0;
    wr_addr = chk_q[AddrW-1:0];
    wr_data = rd_data;
    emit    = 1'b0;
    e_sts   = StsOk;
    e_last  = 1'b0;
    e_ent   = '0;
    e_tally = '0;
    need_emit = 1'b0;
    stall   = 1'b0;
    issue   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        idx_d   = '0;
        v1_d    = 1'b0;
        cnt_d   = '0;
        k_d     = '0;
        found_d = 1'b0;
        if (accept) begin
          if (command_i == CmdCount || (command_i == CmdAdd &&
              key_high_i == '0 && key_low_i == '0)) begin
            state_d = S_FIN;
          end else if (command_i <= CmdTimeout) begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        need_emit = ((cmd_q == CmdSnapshot) && v1_q && (rd_data.st == sv_q) && (k_q < lim_q)) ||
                    ((cmd_q == CmdTimeout) && elig && (k_q < lim_q));
        stall = need_emit && !ofree;
        if (!stall) begin
          if (find_cmd && key_eq && !found_q) begin
            found_d = 1'b1;
            slot_d  = chk_q;
            hit_d   = rd_data;
            if (cmd_q == CmdSetState) begin
              wr_en      = 1'b1;
              wr_data.st = sv_q;
            end else if (cmd_q == CmdBeat) begin
              wr_en      = 1'b1;
              wr_data.hb = tm_q;
            end
          end
          if (cmd_q == CmdCountSt && v1_q && rd_data.st == sv_q) begin
            cnt_d = cnt_q + 1'b1;
          end
          if (cmd_q == CmdTimeout && elig) begin
            wr_en      = 1'b1;
            wr_data.st = StSuspect;
            cnt_d      = cnt_q + 1'b1;
          end
          if (need_emit) begin
            emit  = 1'b1;
            e_ent = rd_data;
            // report a flagged worker with its new state
            if (cmd_q == CmdTimeout) e_ent.st = StSuspect;
            k_d   = k_q + 1'b1;
          end
          issue = (idx_q < occ_q) && !(find_cmd && found_d) &&
                  !((cmd_q == CmdSnapshot) && (k_d >= lim_q));
          rd_en = issue;
          v1_d  = issue;
          chk_d = idx_q;
          if (issue) begin
            idx_d = idx_q + 1'b1;
          end else begin
            state_d = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (ofree) begin
          emit    = 1'b1;
          e_last  = 1'b1;
          state_d = S_IDLE;
          case (cmd_q)
            CmdAdd: begin
              if (ekey_q) begin
                e_sts = StsEmptyKey;
              end else if (!found_q) begin
                if (occ_q >= DepthC) begin
                  e_sts = StsFull;
                end else begin
                  wr_en   = 1'b1;
                  wr_addr = occ_q[AddrW-1:0];
                  wr_data = '{kh: kh_q, kl: kl_q, st: StAvailable, hb: '0};
                  occ_d   = occ_q + 1'b1;
                end
              end
            end
            CmdRemove: begin
              if (found_q) begin
                emit    = 1'b0;
                state_d = S_REMRD;
              end else begin
                e_sts = StsNotFound;
              end
            end
            CmdSetState, CmdBeat: e_sts = found_q ? StsOk : StsNotFound;
            CmdLookup: begin
              if (found_q) e_ent = hit_q;
              else e_sts = StsNotFound;
            end
            CmdCount:    e_tally = occ_q;
            CmdCountSt:  e_tally = cnt_q;
            CmdSnapshot: e_tally = k_q;
            CmdTimeout:  e_tally = cnt_q;
            default: ;
          endcase
        end
      end

      S_REMRD: begin
        rd_en   = 1'b1;
        rd_addr = AddrW'(occ_q - 1'b1);
        state_d = S_REMWR;
      end

      S_REMWR: begin
        if (ofree) begin
          wr_en   = 1'b1;
          wr_addr = slot_q[AddrW-1:0];
          wr_data = rd_data;
          occ_d   = occ_q - 1'b1;
          emit    = 1'b1;
          e_last  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      occ_q     <= '0;
      timeout_q <= TimeoutRst;
      limit_q   <= MaxReport;
      ovalid_q  <= 1'b0;
      v1_q      <= 1'b0;
      found_q   <= 1'b0;
      idx_q     <= '0;
      chk_q     <= '0;
      cnt_q     <= '0;
      k_q       <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      v1_q    <= v1_d;
      found_q <= found_d;
      idx_q   <= idx_d;
      chk_q   <= chk_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      if (cfg_we_i) begin
        if (cfg_index_i == RegTimeout) timeout_q <= cfg_data_i;
        else if (cfg_index_i == RegLimit) limit_q <= cfg_data_i[CntW-1:0];
      end
      if (emit) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    hit_q  <= hit_d;
    if (accept) begin
      cmd_q  <= command_i;
      kh_q   <= key_high_i;
      kl_q   <= key_low_i;
      sv_q   <= state_value_i;
      tm_q   <= time_ms_i;
      ekey_q <= (key_high_i == '0) && (key_low_i == '0);
      lim_q  <= (limit_q > MaxReport) ? MaxReport : limit_q;
    end
    if (emit) begin
      osts_q   <= e_sts;
      olast_q  <= e_last;
      oent_q   <= e_ent;
      otally_q <= e_tally;
    end
  end

  assign out_valid_o       = ovalid_q;
  assign status_o          = osts_q;
  assign last_o            = olast_q;
  assign entry_key_high_o  = oent_q.kh;
  assign entry_key_low_o   = oent_q.kl;
  assign entry_state_o     = oent_q.st;
  assign entry_heartbeat_o = oent_q.hb;
  assign tally_o           = otally_q;

endmodule
